/* hw/rtl/assert_macros.svh */
// Assertion macros shared by the execute unit RTL.
// Depends on nothing; included by modules that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that an antecedent implies a consequent in the same cycle.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// Check that an antecedent implies a consequent in the next cycle.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

/* hw/rtl/cboe_pkg.sv */
// Package for the basic-op execute unit: opcodes, widths and the stage bundle.
// Depends on nothing.
package cboe_pkg;

    localparam int unsigned DataW = 16;
    localparam int unsigned QuotW = 32;
    localparam int unsigned DivSteps = 32;
    localparam int unsigned DefStepsPerStage = 2;

    localparam logic [4:0] OP_SET = 5'h01;
    localparam logic [4:0] OP_ADD = 5'h02;
    localparam logic [4:0] OP_SUB = 5'h03;
    localparam logic [4:0] OP_MUL = 5'h04;
    localparam logic [4:0] OP_MLI = 5'h05;
    localparam logic [4:0] OP_DIV = 5'h06;
    localparam logic [4:0] OP_DVI = 5'h07;
    localparam logic [4:0] OP_MOD = 5'h08;
    localparam logic [4:0] OP_MDI = 5'h09;
    localparam logic [4:0] OP_AND = 5'h0A;
    localparam logic [4:0] OP_BOR = 5'h0B;
    localparam logic [4:0] OP_XOR = 5'h0C;
    localparam logic [4:0] OP_SHR = 5'h0D;
    localparam logic [4:0] OP_ASR = 5'h0E;
    localparam logic [4:0] OP_SHL = 5'h0F;
    localparam logic [4:0] OP_IFB = 5'h10;
    localparam logic [4:0] OP_IFC = 5'h11;
    localparam logic [4:0] OP_IFE = 5'h12;
    localparam logic [4:0] OP_IFN = 5'h13;
    localparam logic [4:0] OP_IFG = 5'h14;
    localparam logic [4:0] OP_IFA = 5'h15;
    localparam logic [4:0] OP_IFL = 5'h16;
    localparam logic [4:0] OP_IFU = 5'h17;
    localparam logic [4:0] OP_ADX = 5'h1A;
    localparam logic [4:0] OP_SBX = 5'h1B;
    localparam logic [4:0] OP_STI = 5'h1E;
    localparam logic [4:0] OP_STD = 5'h1F;

    localparam logic [1:0] STEP_NONE = 2'b00;
    localparam logic [1:0] STEP_INC = 2'b01;
    localparam logic [1:0] STEP_DEC = 2'b11;

    // Result of the front stage, plus divider work for divide/modulo ops.
    typedef struct packed {
        logic [DataW-1:0] result;
        logic             write_result;
        logic [DataW-1:0] ex_out;
        logic             ex_write;
        logic             skip_next;
        logic [1:0]       index_step;
        logic             is_div;      // finish as a division/modulo
        logic             want_rem;    // take remainder (MOD/MDI)
        logic             neg_q;       // negate quotient at the end
        logic             neg_r;       // negate remainder at the end
        logic             zero_div;    // divisor was zero
    } t_res;

    typedef struct packed {
        logic [QuotW-1:0]   rem;    // partial remainder
        logic [QuotW-1:0]   quo;    // dividend shifting in, quotient out
        logic [DataW-1:0]   dvs;    // divisor magnitude
    } t_div;

endpackage

/* hw/rtl/cboe_front.sv */
// Front stage of the execute unit: decode and the combinational non-divide operations.
// Depends on cboe_pkg. Prepares divider magnitudes for DIV/DVI/MOD/MDI.
module cboe_front (
    input  logic [4:0]                    i_op,
    input  logic [cboe_pkg::DataW-1:0]    i_b,
    input  logic [cboe_pkg::DataW-1:0]    i_a,
    input  logic [cboe_pkg::DataW-1:0]    i_ex,
    output cboe_pkg::t_res                o_res,
    output cboe_pkg::t_div                o_div
);
    logic [31:0] wide;
    logic        use_wide;
    logic [31:0] umul;
    logic [31:0] smul;
    logic [31:0] bsh;
    logic [31:0] asr;
    logic        sb_neg;
    logic        sa_neg;
    logic [15:0] mag_b;
    logic [15:0] mag_a;
    logic        signed_div;
    logic        rem_op;
    logic        sgt;
    logic        slt;

    assign sb_neg = i_b[15];
    assign sa_neg = i_a[15];
    assign umul = {16'd0, i_b} * {16'd0, i_a};
    assign smul = 32'($signed({{16{i_b[15]}}, i_b}) * $signed({{16{i_a[15]}}, i_a}));
    assign bsh = {i_b, 16'd0};
    assign asr = (i_a >= 16'd32) ? {32{sb_neg}} : 32'($signed(bsh) >>> i_a[4:0]);
    assign sgt = $signed(i_b) > $signed(i_a);
    assign slt = $signed(i_b) < $signed(i_a);
    assign signed_div = (i_op == cboe_pkg::OP_DVI) || (i_op == cboe_pkg::OP_MDI);
    assign rem_op = (i_op == cboe_pkg::OP_MOD) || (i_op == cboe_pkg::OP_MDI);
    assign mag_b = (signed_div && sb_neg) ? 16'(-i_b) : i_b;
    assign mag_a = (signed_div && sa_neg) ? 16'(-i_a) : i_a;

    always_comb begin
        o_res = '0;
        wide = '0;
        use_wide = 1'b0;
        unique case (i_op)
            cboe_pkg::OP_SET: begin
                o_res.result = i_a;
                o_res.write_result = 1'b1;
            end
            cboe_pkg::OP_ADD: begin
                wide = {16'd0, i_b} + {16'd0, i_a};
                use_wide = 1'b1;
            end
            cboe_pkg::OP_SUB: begin
                wide = {16'd0, i_b} - {16'd0, i_a};
                use_wide = 1'b1;
            end
            cboe_pkg::OP_MUL: begin
                wide = umul;
                use_wide = 1'b1;
            end
            cboe_pkg::OP_MLI: begin
                wide = smul;
                use_wide = 1'b1;
            end
            cboe_pkg::OP_DIV, cboe_pkg::OP_DVI: begin
                o_res.write_result = 1'b1;
                o_res.ex_write = 1'b1;
                o_res.is_div = 1'b1;
                o_res.neg_q = signed_div && (sb_neg ^ sa_neg);
                o_res.zero_div = (i_a == 16'd0);
            end
            cboe_pkg::OP_MOD, cboe_pkg::OP_MDI: begin
                o_res.write_result = 1'b1;
                o_res.is_div = 1'b1;
                o_res.want_rem = 1'b1;
                o_res.neg_r = signed_div && sb_neg;
                o_res.zero_div = (i_a == 16'd0);
            end
            cboe_pkg::OP_AND: begin
                o_res.result = i_b & i_a;
                o_res.write_result = 1'b1;
            end
            cboe_pkg::OP_BOR: begin
                o_res.result = i_b | i_a;
                o_res.write_result = 1'b1;
            end
            cboe_pkg::OP_XOR: begin
                o_res.result = i_b ^ i_a;
                o_res.write_result = 1'b1;
            end
            cboe_pkg::OP_SHR: begin
                o_res.write_result = 1'b1;
                o_res.ex_write = 1'b1;
                if (i_a < 16'd32) begin
                    o_res.result = 16'({16'd0, i_b} >> i_a[4:0]);
                    o_res.ex_out = 16'(bsh >> i_a[4:0]);
                end
            end
            cboe_pkg::OP_ASR: begin
                o_res.write_result = 1'b1;
                o_res.ex_write = 1'b1;
                o_res.result = asr[31:16];
                o_res.ex_out = asr[15:0];
            end
            cboe_pkg::OP_SHL: begin
                o_res.write_result = 1'b1;
                o_res.ex_write = 1'b1;
                if (i_a < 16'd32) begin
                    o_res.result = 16'({16'd0, i_b} << i_a[4:0]);
                    o_res.ex_out = 16'(({16'd0, i_b} << i_a[4:0]) >> 16);
                end
            end
            cboe_pkg::OP_IFB: o_res.skip_next = ((i_b & i_a) == 16'd0);
            cboe_pkg::OP_IFC: o_res.skip_next = ((i_b & i_a) != 16'd0);
            cboe_pkg::OP_IFE: o_res.skip_next = (i_b != i_a);
            cboe_pkg::OP_IFN: o_res.skip_next = (i_b == i_a);
            cboe_pkg::OP_IFG: o_res.skip_next = !(i_b > i_a);
            cboe_pkg::OP_IFA: o_res.skip_next = !sgt;
            cboe_pkg::OP_IFL: o_res.skip_next = !(i_b < i_a);
            cboe_pkg::OP_IFU: o_res.skip_next = !slt;
            cboe_pkg::OP_ADX: begin
                wide = {16'd0, i_b} + {16'd0, i_a} + {16'd0, i_ex};
                use_wide = 1'b1;
            end
            cboe_pkg::OP_SBX: begin
                // Nonzero EX folds in EX minus 0x10000.
                if (i_ex != 16'd0)
                    wide = {16'd0, i_b} - {16'd0, i_a} + {16'd0, i_ex} - 32'h0001_0000;
                else
                    wide = {16'd0, i_b} - {16'd0, i_a};
                use_wide = 1'b1;
            end
            cboe_pkg::OP_STI: begin
                o_res.result = i_a;
                o_res.write_result = 1'b1;
                o_res.index_step = cboe_pkg::STEP_INC;
            end
            cboe_pkg::OP_STD: begin
                o_res.result = i_a;
                o_res.write_result = 1'b1;
                o_res.index_step = cboe_pkg::STEP_DEC;
            end
            default: ;
        endcase
        if (use_wide) begin
            o_res.result = wide[15:0];
            o_res.write_result = 1'b1;
            o_res.ex_out = wide[31:16];
            o_res.ex_write = 1'b1;
        end
    end

    // Divide: dividend is b<<16; quotient low half is EX, high half the result.
    // Modulo: dividend is b itself so the final remainder is b mod a.
    assign o_div.rem = '0;
    assign o_div.quo = rem_op ? {16'd0, mag_b} : {mag_b, 16'd0};
    assign o_div.dvs = mag_a;
endmodule

/* hw/rtl/cboe_div_stage.sv */
// One pipeline stage of the restoring divider: STEPS quotient bits per stage.
// Depends on cboe_pkg.
module cboe_div_stage #(
    parameter int unsigned STEPS = cboe_pkg::DefStepsPerStage
) (
    input  cboe_pkg::t_div i_div,
    output cboe_pkg::t_div o_div
);
    always_comb begin
        logic [cboe_pkg::QuotW:0] trial;
        o_div = i_div;
        for (int k = 0; k < STEPS; k++) begin
            trial = {o_div.rem, o_div.quo[cboe_pkg::QuotW-1]}
                - {17'd0, o_div.dvs};
            if (!trial[cboe_pkg::QuotW]) begin
                o_div.rem = trial[cboe_pkg::QuotW-1:0];
                o_div.quo = {o_div.quo[cboe_pkg::QuotW-2:0], 1'b1};
            end else begin
                o_div.rem = {o_div.rem[cboe_pkg::QuotW-2:0],
                    o_div.quo[cboe_pkg::QuotW-1]};
                o_div.quo = {o_div.quo[cboe_pkg::QuotW-2:0], 1'b0};
            end
        end
    end
endmodule

/* hw/rtl/cpu_basic_op_execute.sv */
// Top level of the basic-op execute unit: front stage, divider pipe, output.
// Depends on cboe_pkg, cboe_front, cboe_div_stage and assert_macros.svh.
//
// Usage:
//   Input channel i_valid/o_ready carries op, b, a and EX; output channel
//   o_valid/i_ready carries the result, EX and write/skip/index flags.
//   Every op runs the same pipe so results leave in order: one front stage,
//   DivSteps/STEPS_PER_STAGE divider stages (16 at the default of two bits
//   per stage) and a final fix-up stage that drives the ports.
//   Throughput: one transfer per cycle while the receiver does not stall; the divider is fully pipelined.
//   Reset clears every stage valid bit; payloads are not reset.
//   When the receiver stalls, the whole pipe holds (one global enable from
//   the output stage), and o_ready drops only while the last stage is full
//   and not taken; nothing is lost or repeated.
`include "assert_macros.svh"
module cpu_basic_op_execute #(
    parameter int unsigned STEPS_PER_STAGE = cboe_pkg::DefStepsPerStage
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [4:0]  i_op,
    input  logic [15:0] i_b_value,
    input  logic [15:0] i_a_value,
    input  logic [15:0] i_ex_in,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [15:0] o_result,
    output logic        o_write_result,
    output logic [15:0] o_ex_out,
    output logic        o_ex_write,
    output logic        o_skip_next,
    output logic signed [1:0] o_index_step
);
    localparam int unsigned NStages = cboe_pkg::DivSteps / STEPS_PER_STAGE;

    cboe_pkg::t_res f_res;
    cboe_pkg::t_div f_div;
    cboe_pkg::t_res r_res [NStages+1];
    cboe_pkg::t_div r_div [NStages+1];
    logic           r_vld [NStages+1];
    cboe_pkg::t_div d_out [NStages];
    logic           r_ov;
    logic [15:0]    r_result;
    logic [15:0]    r_ex;
    logic           r_wr;
    logic           r_exw;
    logic           r_skip;
    logic [1:0]     r_step;
    logic           adv;
    cboe_pkg::t_res last;
    cboe_pkg::t_div ldiv;
    logic [15:0]    n_result;
    logic [15:0]    n_ex;

    // Advance the whole pipe whenever the output register is free or taken.
    assign adv = !r_ov || i_ready;
    assign o_ready = adv;

    cboe_front u_front (
        .i_op(i_op), .i_b(i_b_value), .i_a(i_a_value), .i_ex(i_ex_in),
        .o_res(f_res), .o_div(f_div)
    );

    for (genvar g = 0; g < NStages; g++) begin : g_div
        cboe_div_stage #(.STEPS(STEPS_PER_STAGE)) u_stage (
            .i_div(r_div[g]), .o_div(d_out[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= NStages; k++) r_vld[k] <= 1'b0;
        end else if (adv) begin
            r_vld[0] <= i_valid;
            for (int k = 1; k <= NStages; k++) r_vld[k] <= r_vld[k-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_res[0] <= f_res;
            r_div[0] <= f_div;
            for (int k = 1; k <= NStages; k++) begin
                r_res[k] <= r_res[k-1];
                r_div[k] <= d_out[k-1];
            end
        end
    end

    // Sign fix-up and zero-divisor handling for the finished division.
    assign last = r_res[NStages];
    assign ldiv = r_div[NStages];
    always_comb begin
        n_result = last.result;
        n_ex = last.ex_out;
        if (last.is_div) begin
            if (last.zero_div) begin
                n_result = '0;
                n_ex = '0;
            end else if (last.want_rem) begin
                n_result = last.neg_r ? 16'(-ldiv.rem[15:0]) : ldiv.rem[15:0];
                n_ex = '0;
            end else begin
                n_result = last.neg_q ? 16'(-ldiv.quo[31:16]) : ldiv.quo[31:16];
                n_ex = last.neg_q ? 16'(-ldiv.quo) : ldiv.quo[15:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (adv) begin
            r_ov <= r_vld[NStages];
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_result <= n_result;
            r_ex <= n_ex;
            r_wr <= last.write_result;
            r_exw <= last.ex_write;
            r_skip <= last.skip_next;
            r_step <= last.index_step;
        end
    end

    assign o_valid = r_ov;
    assign o_result = r_result;
    assign o_ex_out = r_ex;
    assign o_write_result = r_wr;
    assign o_ex_write = r_exw;
    assign o_skip_next = r_skip;
    assign o_index_step = r_step;

    `ASSERT_NEXT(a_hold_out, i_clk, i_rst_n, o_valid && !i_ready, o_valid && $stable(o_result))
    `ASSERT_IMPLY(a_ready_free, i_clk, i_rst_n, !o_valid, o_ready)
    `ASSERT_IMPLY(a_skip_excl, i_clk, i_rst_n, o_valid && o_skip_next, !o_write_result && !o_ex_write)
endmodule

/* tb/tb.sv */
// Testbench for cpu_basic_op_execute: directed and random basic ops, predicted per item.
// Depends on cboe_pkg and the execute unit RTL.
module tb;

    typedef struct {
        logic [15:0] result;
        logic        write_result;
        logic [15:0] ex_out;
        logic        ex_write;
        logic        skip_next;
        logic [1:0]  index_step;
    } t_outcome;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    logic [4:0]  i_op;
    logic [15:0] i_b_value;
    logic [15:0] i_a_value;
    logic [15:0] i_ex_in;
    logic        o_valid;
    logic        i_ready;
    logic [15:0] o_result;
    logic        o_write_result;
    logic [15:0] o_ex_out;
    logic        o_ex_write;
    logic        o_skip_next;
    logic signed [1:0] o_index_step;

    t_outcome pending_results[$];
    int       fail_count;
    int       burst_left;
    bit       stall_mode;

    cpu_basic_op_execute dut (.*);

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #20000000;
        $display("tb failed");
        $finish;
    end

    // Compute what the execute unit should answer for one instruction.
    function automatic t_outcome execute_op(logic [4:0] op, logic [15:0] b,
                                            logic [15:0] a, logic [15:0] ex);
        t_outcome    r;
        logic [31:0] wide;
        logic [31:0] sh;
        logic [31:0] ur;
        longint      sb;
        longint      sa;
        longint      q;
        longint      qe;
        bit          use_wide;
        r = '{default: '0};
        wide = '0;
        use_wide = 1'b0;
        sb = longint'($signed(b));
        sa = longint'($signed(a));
        case (op)
            cboe_pkg::OP_SET: begin
                r.result = a; r.write_result = 1'b1;
            end
            cboe_pkg::OP_ADD: begin wide = {16'h0, b} + {16'h0, a}; use_wide = 1'b1; end
            cboe_pkg::OP_SUB: begin wide = {16'h0, b} - {16'h0, a}; use_wide = 1'b1; end
            cboe_pkg::OP_MUL: begin wide = {16'h0, b} * {16'h0, a}; use_wide = 1'b1; end
            cboe_pkg::OP_MLI: begin wide = 32'(sb * sa); use_wide = 1'b1; end
            cboe_pkg::OP_DIV: begin
                r.write_result = 1'b1; r.ex_write = 1'b1;
                if (a != 0) begin
                    r.result = 16'(b / a);
                    r.ex_out = 16'(({16'h0, b} << 16) / {16'h0, a});
                end
            end
            cboe_pkg::OP_DVI: begin
                r.write_result = 1'b1; r.ex_write = 1'b1;
                if (sa != 0) begin
                    q = sb / sa;
                    qe = (sb * 65536) / sa;
                    r.result = 16'(q);
                    r.ex_out = 16'(qe);
                end
            end
            cboe_pkg::OP_MOD: begin
                r.write_result = 1'b1;
                r.result = (a != 0) ? b % a : 16'h0;
            end
            cboe_pkg::OP_MDI: begin
                r.write_result = 1'b1;
                r.result = (sa != 0) ? 16'(sb % sa) : 16'h0;
            end
            cboe_pkg::OP_AND: begin r.write_result = 1'b1; r.result = b & a; end
            cboe_pkg::OP_BOR: begin r.write_result = 1'b1; r.result = b | a; end
            cboe_pkg::OP_XOR: begin r.write_result = 1'b1; r.result = b ^ a; end
            cboe_pkg::OP_SHR: begin
                r.write_result = 1'b1; r.ex_write = 1'b1;
                if (a < 32) begin
                    r.result = b >> a;
                    sh = {b, 16'h0} >> a;
                    r.ex_out = sh[15:0];
                end
            end
            cboe_pkg::OP_ASR: begin
                r.write_result = 1'b1; r.ex_write = 1'b1;
                // Sign fill saturates once the amount reaches 32, the width of b with its zero low half.
                if (a >= 32) sh = b[15] ? 32'hFFFF_FFFF : 32'h0;
                else sh = $unsigned($signed({b, 16'h0}) >>> a);
                r.result = sh[31:16];
                r.ex_out = sh[15:0];
            end
            cboe_pkg::OP_SHL: begin
                r.write_result = 1'b1; r.ex_write = 1'b1;
                if (a < 32) begin
                    ur = {16'h0, b} << a;
                    r.result = ur[15:0];
                    r.ex_out = ur[31:16];
                end
            end
            cboe_pkg::OP_IFB: r.skip_next = (b & a) == 0;
            cboe_pkg::OP_IFC: r.skip_next = (b & a) != 0;
            cboe_pkg::OP_IFE: r.skip_next = b != a;
            cboe_pkg::OP_IFN: r.skip_next = b == a;
            cboe_pkg::OP_IFG: r.skip_next = !(b > a);
            cboe_pkg::OP_IFA: r.skip_next = !(sb > sa);
            cboe_pkg::OP_IFL: r.skip_next = !(b < a);
            cboe_pkg::OP_IFU: r.skip_next = !(sb < sa);
            cboe_pkg::OP_ADX: begin
                wide = {16'h0, b} + {16'h0, a} + {16'h0, ex}; use_wide = 1'b1;
            end
            cboe_pkg::OP_SBX: begin
                // Keep the quirk: nonzero EX adds EX minus 0x10000.
                if (ex != 0) wide = {16'h0, b} - {16'h0, a} + {16'h0, ex} - 32'h10000;
                else wide = {16'h0, b} - {16'h0, a};
                use_wide = 1'b1;
            end
            cboe_pkg::OP_STI: begin
                r.write_result = 1'b1; r.result = a; r.index_step = cboe_pkg::STEP_INC;
            end
            cboe_pkg::OP_STD: begin
                r.write_result = 1'b1; r.result = a; r.index_step = cboe_pkg::STEP_DEC;
            end
            default: ;
        endcase
        if (use_wide) begin
            r.write_result = 1'b1; r.ex_write = 1'b1;
            r.result = wide[15:0];
            r.ex_out = wide[31:16];
        end
        return r;
    endfunction

    // Drive one instruction, hold it until transfer, then idle per burst pattern.
    task automatic send_op(logic [4:0] op, logic [15:0] b, logic [15:0] a,
                           logic [15:0] ex);
        i_valid <= 1'b1;
        i_op <= op;
        i_b_value <= b;
        i_a_value <= a;
        i_ex_in <= ex;
        pending_results.push_back(execute_op(op, b, a, ex));
        do @(posedge i_clk); while (!o_ready);
        @(negedge i_clk);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(0, 20);
            if ($urandom_range(0, 2) != 0) begin
                i_valid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(negedge i_clk);
            end
        end
    endtask

    // Receiver: alternate between free-running and stall-heavy stretches.
    always @(negedge i_clk) begin
        if ($urandom_range(0, 63) == 0) stall_mode = ~stall_mode;
        i_ready <= stall_mode ? ($urandom_range(0, 3) == 0) : 1'b1;
    end

    // Compare every transfer on the output with the oldest prediction.
    always @(posedge i_clk) begin
        t_outcome exp_r;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result %h", $time, o_result);
                fail_count++;
            end else begin
                exp_r = pending_results.pop_front();
                if (o_result !== exp_r.result)
                    $display("%0t: result exp %h got %h", $time, exp_r.result, o_result);
                if (o_write_result !== exp_r.write_result)
                    $display("%0t: write_result exp %b got %b", $time,
                             exp_r.write_result, o_write_result);
                if (o_ex_out !== exp_r.ex_out)
                    $display("%0t: ex_out exp %h got %h", $time, exp_r.ex_out, o_ex_out);
                if (o_ex_write !== exp_r.ex_write)
                    $display("%0t: ex_write exp %b got %b", $time,
                             exp_r.ex_write, o_ex_write);
                if (o_skip_next !== exp_r.skip_next)
                    $display("%0t: skip_next exp %b got %b", $time,
                             exp_r.skip_next, o_skip_next);
                if (o_index_step !== exp_r.index_step)
                    $display("%0t: index_step exp %b got %b", $time,
                             exp_r.index_step, o_index_step);
                if (o_result !== exp_r.result || o_write_result !== exp_r.write_result
                    || o_ex_out !== exp_r.ex_out || o_ex_write !== exp_r.ex_write
                    || o_skip_next !== exp_r.skip_next
                    || o_index_step !== exp_r.index_step)
                    fail_count++;
            end
        end
    end

    task automatic test_every_opcode();
        for (int op = 0; op < 32; op++)
            send_op(5'(op), 16'(op * 16'h0931), 16'h0003, 16'h0001);
    endtask

    task automatic test_special_cases();
        send_op(cboe_pkg::OP_DIV, 16'h1234, 16'h0000, 16'h0);
        send_op(cboe_pkg::OP_DVI, 16'h8000, 16'h0000, 16'h0);
        send_op(cboe_pkg::OP_MOD, 16'hFFFF, 16'h0000, 16'h0);
        send_op(cboe_pkg::OP_MDI, 16'h8001, 16'h0000, 16'h0);
        send_op(cboe_pkg::OP_DVI, 16'h8000, 16'hFFFF, 16'h0);
        send_op(cboe_pkg::OP_MDI, 16'hFFF9, 16'h0002, 16'h0);
        send_op(cboe_pkg::OP_DVI, 16'h0007, 16'hFFFE, 16'h0);
        send_op(cboe_pkg::OP_SHR, 16'hFFFF, 16'd32, 16'h0);
        send_op(cboe_pkg::OP_SHL, 16'hFFFF, 16'd31, 16'h0);
        send_op(cboe_pkg::OP_ASR, 16'h8000, 16'hFFFF, 16'h0);
        send_op(cboe_pkg::OP_ASR, 16'h7FFF, 16'd32, 16'h0);
        send_op(cboe_pkg::OP_SBX, 16'h0000, 16'hFFFF, 16'hFFFF);
        send_op(cboe_pkg::OP_ADX, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_op(cboe_pkg::OP_MLI, 16'h8000, 16'h8000, 16'h0);
        send_op(cboe_pkg::OP_IFA, 16'h8000, 16'h7FFF, 16'h0);
        send_op(cboe_pkg::OP_IFU, 16'h8000, 16'h7FFF, 16'h0);
    endtask

    // Mostly full-range values; some small shift amounts and operand extremes.
    task automatic test_random_ops(int count);
        logic [15:0] b;
        logic [15:0] a;
        for (int k = 0; k < count; k++) begin
            b = 16'($urandom);
            a = 16'($urandom);
            case ($urandom_range(0, 5))
                0: a = 16'($urandom_range(0, 40));
                1: a = $urandom_range(0, 1) ? 16'hFFFF : 16'h0;
                2: b = $urandom_range(0, 1) ? 16'h8000 : 16'h7FFF;
                default: ;
            endcase
            send_op(5'($urandom), b, a, $urandom_range(0, 3) == 0 ? 16'h0 : 16'($urandom));
        end
    endtask

    initial begin
        fail_count = 0;
        burst_left = 0;
        stall_mode = 1'b0;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_ready = 1'b0;
        i_op = '0;
        i_b_value = '0;
        i_a_value = '0;
        i_ex_in = '0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_every_opcode();
        test_special_cases();
        test_random_ops(1350);
        i_valid <= 1'b0;
        wait (pending_results.size() == 0);
        repeat (40) @(posedge i_clk);
        if (fail_count == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end
endmodule
